// File: hw/rtl/dbp_pkg.sv
package dbp_pkg;

    // Buffer geometry
    localparam int CNT_W = 14;
    localparam int LEN_W = 10;
    localparam logic [CNT_W-1:0] BUF_BYTES   = 14'd8192;
    localparam logic [CNT_W-1:0] CHUNK_BYTES = 14'd512;

    // Request kinds (tuser)
    localparam logic [2:0] REQ_OPEN    = 3'd0;
    localparam logic [2:0] REQ_PUMP    = 3'd1;
    localparam logic [2:0] REQ_CONSUME = 3'd2;
    localparam logic [2:0] REQ_SEEK    = 3'd3;
    localparam logic [2:0] REQ_CLOSE   = 3'd4;

    // Stream phases
    localparam logic [2:0] PH_CLOSED = 3'd0;
    localparam logic [2:0] PH_FILL_A = 3'd1;
    localparam logic [2:0] PH_FILL_B = 3'd2;
    localparam logic [2:0] PH_READY  = 3'd3;
    localparam logic [2:0] PH_END    = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    // Grant status
    localparam logic [1:0] GS_OK        = 2'd0;
    localparam logic [1:0] GS_NOT_READY = 2'd1;
    localparam logic [1:0] GS_END       = 2'd2;

    // Classified request word
    typedef struct packed {
        logic        is_open;
        logic        is_pump;
        logic        is_consume;
        logic        is_seek;
        logic        is_close;
        logic [31:0] file_length;
        logic [31:0] target_position;
        logic [15:0] byte_limit;
        logic [9:0]  bytes_delivered;
        logic        storage_error;
    } t_req;

    // Result word
    typedef struct packed {
        logic [2:0]       stream_phase;
        logic             fill_buffer;
        logic [CNT_W-1:0] fill_start;
        logic [LEN_W-1:0] fill_length;
        logic [CNT_W-1:0] grant_count;
        logic [1:0]       grant_status;
        logic             grant_buffer;
        logic [12:0]      grant_offset;
        logic [CNT_W-1:0] bytes_available;
        logic [31:0]      logical_position;
        logic             at_end;
        logic             fill_advanced;
    } t_res;

    // Unconsumed bytes of one buffer
    function automatic logic [CNT_W-1:0] unread(input logic [CNT_W-1:0] valid,
                                                input logic [CNT_W-1:0] used);
        unread = (used >= valid) ? '0 : valid - used;
    endfunction

endpackage

// File: hw/rtl/double_buffer_prefetch_ctrl.sv
// Prefetch bookkeeping for one byte stream read ahead into two ping-pong
// buffers (A and B). Requests come in on the s_axis channel: tuser is the
// request kind (open, pump, consume, seek, close), tdata carries its
// arguments. Every request yields exactly one result word on m_axis with
// the fill read to issue, the consume grant, bytes available, the logical
// position and the end flag.
// Each accepted request is written into the request queue; the back end
// then loads the result register from the queue head once that register
// is empty or its word is being taken.
// Throughput: one request per cycle while results are taken; counter
// updates are combinational, so the state loop closes every clock.
// Reset (synchronous, i_rst_n low) leaves the stream closed with all
// counters zero and both channels empty.
// When the receiver stalls, the result register holds its word; the
// two-entry request queue keeps accepting until it fills, then s_axis
// tready drops.
module double_buffer_prefetch_ctrl
    import dbp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // file_length[31:0], target_position[63:32], byte_limit[79:64],
    // bytes_delivered[89:80], storage_error[90], zero[95:91]
    input  logic [95:0]  i_s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // stream_phase[2:0], fill_buffer[3], fill_start[17:4], fill_length[27:18],
    // grant_count[41:28], grant_status[43:42], grant_buffer[44],
    // grant_offset[57:45], bytes_available[71:58], logical_position[103:72],
    // at_end[104], fill_advanced[105], zero[111:106]
    output logic [111:0] o_m_axis_tdata
);

    logic fr_valid;
    t_req fr_req;
    logic q_full;
    logic q_valid;
    t_req q_req;
    logic bk_pop;
    t_res bk_res;

    assign o_s_axis_tready = !q_full;

    // Front: classify requests
    dbp_front u_front (
        .i_valid (i_s_axis_tvalid),
        .i_kind  (i_s_axis_tuser),
        .i_data  (i_s_axis_tdata),
        .o_valid (fr_valid),
        .o_req   (fr_req)
    );

    // Queue between front and back
    dbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid && !q_full),
        .i_req   (fr_req),
        .o_full  (q_full),
        .i_pop   (bk_pop),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    // Back: stream state and result register
    dbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_req   (q_req),
        .o_pop   (bk_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (bk_res)
    );

    // Result word packing
    assign o_m_axis_tdata = {6'b0,
                             bk_res.fill_advanced,
                             bk_res.at_end,
                             bk_res.logical_position,
                             bk_res.bytes_available,
                             bk_res.grant_offset,
                             bk_res.grant_buffer,
                             bk_res.grant_status,
                             bk_res.grant_count,
                             bk_res.fill_length,
                             bk_res.fill_start,
                             bk_res.fill_buffer,
                             bk_res.stream_phase};

endmodule

// File: hw/rtl/dbp_front.sv
module dbp_front
    import dbp_pkg::*;
(
    input  logic        i_valid,
    input  logic [2:0]  i_kind,
    input  logic [95:0] i_data,
    output logic        o_valid,
    output t_req        o_req
);

    // Decode request kind, unpack payload fields
    always_comb begin
        o_req = '0;
        unique case (i_kind)
            REQ_OPEN:    o_req.is_open    = 1'b1;
            REQ_PUMP:    o_req.is_pump    = 1'b1;
            REQ_CONSUME: o_req.is_consume = 1'b1;
            REQ_SEEK:    o_req.is_seek    = 1'b1;
            REQ_CLOSE:   o_req.is_close   = 1'b1;
            default:     o_req.is_close   = 1'b0;
        endcase
        o_req.file_length     = i_data[31:0];
        o_req.target_position = i_data[63:32];
        o_req.byte_limit      = i_data[79:64];
        o_req.bytes_delivered = i_data[89:80];
        o_req.storage_error   = i_data[90];
    end

    assign o_valid = i_valid;

endmodule

// File: hw/rtl/dbp_queue.sv
module dbp_queue
    import dbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_req o_req
);

    t_req       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 2'd1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_req;
    end

endmodule

// File: hw/rtl/dbp_back.sv
module dbp_back
    import dbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    // Stream state
    logic [2:0]       r_phase, n_phase;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_cur, n_cur;
    logic [CNT_W-1:0] r_valid [2];
    logic [CNT_W-1:0] n_valid [2];
    logic [CNT_W-1:0] r_used [2];
    logic [CNT_W-1:0] n_used [2];
    logic             r_act, n_act;
    logic [CNT_W-1:0] r_part, n_part;

    // Result register
    logic             r_out_vld;
    t_res             r_res, n_res;
    logic [31:0]      r_out_cur, n_out_cur;
    logic [CNT_W:0]   r_out_buf, n_out_buf;

    // Step temporaries
    logic [2:0]       ph;
    logic             fb;
    logic             side;
    logic             stop;
    logic [CNT_W-1:0] part, room, nreq, avl, part2;
    logic [31:0]      left, cur2;
    logic [LEN_W-1:0] nlen, got;

    assign o_pop   = i_valid && (!r_out_vld || i_ready);
    assign o_valid = r_out_vld;

    // One request against the stream state
    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_cur    = r_cur;
        n_valid  = r_valid;
        n_used   = r_used;
        n_act    = r_act;
        n_part   = r_part;
        n_res    = '0;
        ph       = r_phase;
        fb       = 1'b0;
        side     = r_act;
        stop     = 1'b0;
        part     = r_part;
        room     = '0;
        nreq     = '0;
        avl      = '0;
        part2    = '0;
        left     = '0;
        cur2     = r_cur;
        nlen     = '0;
        got      = '0;

        if (i_req.is_open) begin
            n_len   = i_req.file_length;
            n_cur   = '0;
            n_valid = '{default: '0};
            n_used  = '{default: '0};
            n_act   = 1'b0;
            n_part  = '0;
            n_phase = PH_FILL_A;
        end else if (i_req.is_pump) begin
            // re-arm fill of an emptied inactive buffer
            if (r_phase == PH_READY && r_valid[~r_act] == '0 && r_cur < r_len) begin
                ph   = r_act ? PH_FILL_A : PH_FILL_B;
                part = '0;
            end
            n_part = part;
            if (ph == PH_FILL_A || ph == PH_FILL_B) begin
                fb = (ph == PH_FILL_B);
                n_res.fill_advanced = 1'b1;
                if (r_cur >= r_len) begin
                    // end of data: commit what is there
                    n_valid[fb] = part;
                    n_used[fb]  = '0;
                    n_part      = '0;
                    ph = (r_valid[~fb] != '0) ? PH_READY : PH_END;
                end else begin
                    room = (part >= BUF_BYTES) ? '0 : BUF_BYTES - part;
                    left = r_len - r_cur;
                    nreq = (room < CHUNK_BYTES) ? room : CHUNK_BYTES;
                    if (left < {{(32-CNT_W){1'b0}}, nreq}) nreq = left[CNT_W-1:0];
                    nlen = nreq[LEN_W-1:0];
                    n_res.fill_buffer = fb;
                    n_res.fill_start  = part;
                    n_res.fill_length = nlen;
                    if (i_req.storage_error) begin
                        ph = PH_ERROR;
                    end else begin
                        got   = (i_req.bytes_delivered > nlen) ? nlen : i_req.bytes_delivered;
                        part2 = part + {{(CNT_W-LEN_W){1'b0}}, got};
                        cur2  = r_cur + {{(32-LEN_W){1'b0}}, got};
                        n_cur  = cur2;
                        n_part = part2;
                        if (part2 >= BUF_BYTES || cur2 >= r_len) begin
                            // buffer complete
                            n_valid[fb] = part2;
                            n_used[fb]  = '0;
                            n_part      = '0;
                            if (!fb && r_valid[1] == '0 && cur2 < r_len) ph = PH_FILL_B;
                            else ph = PH_READY;
                        end
                    end
                end
            end
            n_phase = ph;
        end else if (i_req.is_consume) begin
            if (r_phase == PH_CLOSED || r_phase == PH_ERROR) begin
                n_res.grant_status = GS_END;
            end else begin
                side = r_act;
                avl  = unread(r_valid[side], r_used[side]);
                if (avl == '0) begin
                    if (r_valid[~side] != '0) begin
                        // swap to the other buffer
                        n_valid[side] = '0;
                        n_used[side]  = '0;
                        side  = ~side;
                        n_act = side;
                        avl   = unread(r_valid[side], r_used[side]);
                    end else begin
                        n_res.grant_status = (r_phase == PH_END) ? GS_END : GS_NOT_READY;
                        stop = 1'b1;
                    end
                end
                if (!stop) begin
                    if (avl == '0) begin
                        n_res.grant_status = (r_phase == PH_END) ? GS_END : GS_NOT_READY;
                    end else begin
                        n_res.grant_count  = ({2'b0, avl} > i_req.byte_limit)
                                             ? i_req.byte_limit[CNT_W-1:0] : avl;
                        n_res.grant_buffer = side;
                        n_res.grant_offset = r_used[side][12:0];
                        n_res.grant_status = GS_OK;
                        n_used[side] = r_used[side] + n_res.grant_count;
                    end
                end
            end
        end else if (i_req.is_seek) begin
            if (r_phase != PH_CLOSED) begin
                if (i_req.storage_error) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_cur   = i_req.target_position;
                    n_valid = '{default: '0};
                    n_used  = '{default: '0};
                    n_act   = 1'b0;
                    n_part  = '0;
                    n_phase = (i_req.target_position < r_len) ? PH_FILL_A : PH_END;
                end
            end
        end else if (i_req.is_close) begin
            n_phase = PH_CLOSED;
        end

        // Report state after the step
        n_res.stream_phase    = n_phase;
        n_res.bytes_available = unread(n_valid[n_act], n_used[n_act]);
        n_res.at_end          = (n_phase == PH_END) && (n_res.bytes_available == '0);
        n_out_cur             = n_cur;
        n_out_buf             = {1'b0, n_res.bytes_available} + {1'b0, n_valid[~n_act]};
    end

    // State and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CLOSED;
            r_len     <= '0;
            r_cur     <= '0;
            r_valid   <= '{default: '0};
            r_used    <= '{default: '0};
            r_act     <= 1'b0;
            r_part    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase   <= n_phase;
                r_len     <= n_len;
                r_cur     <= n_cur;
                r_valid   <= n_valid;
                r_used    <= n_used;
                r_act     <= n_act;
                r_part    <= n_part;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res     <= n_res;
            r_out_cur <= n_out_cur;
            r_out_buf <= n_out_buf;
        end
    end

    // Position behind buffered bytes, floored at zero
    always_comb begin
        o_res = r_res;
        o_res.logical_position = (r_out_cur > {{(31-CNT_W){1'b0}}, r_out_buf})
                                 ? r_out_cur - {{(31-CNT_W){1'b0}}, r_out_buf} : '0;
    end

endmodule

// File: sim/tb_double_buffer_prefetch_ctrl.sv
module tb_double_buffer_prefetch_ctrl;
    import dbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Request kinds the block does not know
    localparam logic [2:0] REQ_UNUSED_5 = 3'd5;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam int RAND_ITEMS = 1450;
    localparam int TAIL_CYCLES = 10;

    // Result word layout: field LSB positions and widths, lowest field first
    localparam int NF = 12;
    localparam int F_LSB [NF] = '{0, 3, 4, 18, 28, 42, 44, 45, 58, 72, 104, 105};
    localparam int F_W   [NF] = '{3, 1, 14, 10, 14, 2, 1, 13, 14, 32, 1, 1};
    string f_name [NF] = '{"stream_phase", "fill_buffer", "fill_start", "fill_length",
                           "grant_count", "grant_status", "grant_buffer", "grant_offset",
                           "bytes_available", "logical_position", "at_end",
                           "fill_advanced"};

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] flen;
        logic [31:0] tpos;
        logic [15:0] maxb;
        logic [9:0]  deliv;
        logic        err;
        logic        hold;   // wait for all results before presenting
    } t_stim_req;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [95:0]  i_s_axis_tdata = '0;
    logic [2:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b1;
    logic [111:0] o_m_axis_tdata;

    double_buffer_prefetch_ctrl u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    t_stim_req    pending [$];
    logic [111:0] result_due [$];
    t_stim_req    cur;
    int           gap_left = 0;
    int           burst_left = 1;
    logic [15:0]  rdy_pat = 16'hFFFF;
    logic [5:0]   rdy_age = '0;
    int           n_errors = 0;
    int           n_accepted = 0;
    int           n_results = 0;

    // Stream bookkeeping mirror, reset values
    logic [2:0]   phase = PH_CLOSED;
    int unsigned  len_total = 0;
    int unsigned  cursor = 0;
    int unsigned  vcnt [2] = '{0, 0};
    int unsigned  ucnt [2] = '{0, 0};
    bit           active = 1'b0;
    int unsigned  partial = 0;

    // Coverage tallies for the summary
    int n_reads = 0;
    int n_grants = 0;
    int n_swaps = 0;
    int n_end_hits = 0;

    function automatic int unsigned unread_bytes(bit side);
        return (ucnt[side] >= vcnt[side]) ? 0 : vcnt[side] - ucnt[side];
    endfunction

    function automatic void drop_buffers();
        vcnt[0] = 0;
        vcnt[1] = 0;
        ucnt[0] = 0;
        ucnt[1] = 0;
        active = 1'b0;
        partial = 0;
    endfunction

    // Advance the mirror by one request, return the packed result word
    function automatic logic [111:0] stream_step(t_stim_req r);
        longint unsigned vals [NF];
        longint unsigned buffered;
        longint unsigned m;
        logic [111:0] res;
        int unsigned fb, foff, flen_o, gcnt, gstat, gbuf, goff, work;
        int unsigned room, left, n, got, avail, lpos;
        bit b, a, stop;
        fb = 0; foff = 0; flen_o = 0;
        gcnt = 0; gstat = GS_OK; gbuf = 0; goff = 0; work = 0;
        stop = 1'b0;
        case (r.kind)
            REQ_OPEN: begin
                len_total = r.flen;
                cursor = 0;
                drop_buffers();
                phase = PH_FILL_A;
            end
            REQ_PUMP: begin
                // ready stream re-arms the emptied other buffer
                if (phase == PH_READY) begin
                    if (vcnt[~active] == 0 && cursor < len_total) begin
                        phase = (active == 1'b1) ? PH_FILL_A : PH_FILL_B;
                        partial = 0;
                    end
                end
                if (phase == PH_FILL_A || phase == PH_FILL_B) begin
                    b = (phase == PH_FILL_B);
                    work = 1;
                    if (cursor >= len_total) begin
                        // no data left: book what we have
                        vcnt[b] = partial;
                        partial = 0;
                        ucnt[b] = 0;
                        phase = (vcnt[~b] > 0) ? PH_READY : PH_END;
                    end else begin
                        room = (partial >= BUF_BYTES) ? 0 : BUF_BYTES - partial;
                        left = len_total - cursor;
                        n = CHUNK_BYTES;
                        if (n > room) n = room;
                        if (n > left) n = left;
                        fb = b;
                        foff = partial;
                        flen_o = n;
                        n_reads++;
                        if (r.err) begin
                            phase = PH_ERROR;
                        end else begin
                            got = (r.deliv > n) ? n : r.deliv;
                            partial += got;
                            cursor += got;
                            if (partial >= BUF_BYTES || cursor >= len_total) begin
                                vcnt[b] = partial;
                                partial = 0;
                                ucnt[b] = 0;
                                if (b == 1'b0 && vcnt[1] == 0 && cursor < len_total)
                                    phase = PH_FILL_B;
                                else
                                    phase = PH_READY;
                            end
                        end
                    end
                end
            end
            REQ_CONSUME: begin
                if (phase == PH_CLOSED || phase == PH_ERROR) begin
                    gstat = GS_END;
                end else begin
                    a = active;
                    avail = unread_bytes(a);
                    if (avail == 0) begin
                        if (vcnt[~a] > 0) begin
                            // active buffer drained: swap
                            vcnt[a] = 0;
                            ucnt[a] = 0;
                            active = ~a;
                            a = ~a;
                            avail = unread_bytes(a);
                            n_swaps++;
                        end else begin
                            gstat = (phase == PH_END) ? GS_END : GS_NOT_READY;
                            stop = 1'b1;
                        end
                    end
                    if (!stop) begin
                        if (avail == 0) begin
                            gstat = (phase == PH_END) ? GS_END : GS_NOT_READY;
                        end else begin
                            gcnt = (r.maxb < avail) ? r.maxb : avail;
                            gbuf = a;
                            goff = ucnt[a];
                            ucnt[a] += gcnt;
                            gstat = GS_OK;
                            if (gcnt > 0) n_grants++;
                        end
                    end
                end
            end
            REQ_SEEK: begin
                if (phase != PH_CLOSED) begin
                    if (r.err) begin
                        phase = PH_ERROR;
                    end else begin
                        cursor = r.tpos;
                        drop_buffers();
                        phase = (r.tpos < len_total) ? PH_FILL_A : PH_END;
                    end
                end
            end
            REQ_CLOSE: begin
                phase = PH_CLOSED;
            end
            default: ;
        endcase

        // Status view after the step
        a = active;
        avail = unread_bytes(a);
        buffered = longint'(avail) + vcnt[~a];
        lpos = (longint'(cursor) > buffered) ? cursor - int'(buffered) : 0;
        if (phase == PH_END && avail == 0) n_end_hits++;
        vals = '{phase, fb, foff, flen_o, gcnt, gstat, gbuf, goff, avail, lpos,
                 (phase == PH_END && avail == 0), work};
        res = '0;
        for (int i = 0; i < NF; i++) begin
            m = (64'd1 << F_W[i]) - 1;
            res |= 112'(vals[i] & m) << F_LSB[i];
        end
        return res;
    endfunction

    task automatic add_req(logic [2:0] kind, logic [31:0] flen, logic [31:0] tpos,
                           logic [15:0] maxb, logic [9:0] deliv, logic err, bit hold);
        t_stim_req r;
        r.kind = kind;
        r.flen = flen;
        r.tpos = tpos;
        r.maxb = maxb;
        r.deliv = deliv;
        r.err = err;
        r.hold = hold;
        pending.push_back(r);
    endtask

    function automatic logic [9:0] pick_deliv();
        int w;
        w = $urandom_range(0, 9);
        if (w < 7) return 10'd512;
        if (w < 9) return 10'($urandom_range(0, 512));
        return 10'd0;
    endfunction

    function automatic logic [15:0] pick_maxb();
        int w;
        w = $urandom_range(0, 9);
        if (w < 5) return 16'($urandom_range(0, 1024));
        if (w < 8) return 16'($urandom_range(0, 9000));
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_length();
        int w;
        w = $urandom_range(0, 19);
        if (w < 8) return $urandom_range(0, 1500);
        if (w < 13) return $urandom_range(1500, 20000);
        if (w < 16) return $urandom_range(16384, 40000);
        if (w < 18) return $urandom;
        // buffer and chunk boundaries
        case ($urandom_range(0, 3))
            0: return 32'd512;
            1: return 32'd8192;
            2: return 32'd16384;
            default: return 32'd8193;
        endcase
    endfunction

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Request driver: bursts with random gaps, holds on marked words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                result_due.push_back(stream_step(cur));
                n_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending.size() > 0 &&
                             !(pending[0].hold && result_due.size() > 0)) begin
                    cur = pending.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {5'b0, cur.err, cur.deliv, cur.maxb, cur.tpos, cur.flen};
                    i_s_axis_tuser <= cur.kind;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: rotating pattern, reshuffled each time the age counter wraps
    always @(posedge i_clk) begin : rx_stall
        logic [15:0] nxt;
        if (rdy_age == 6'd63)
            nxt = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        else
            nxt = {rdy_pat[0], rdy_pat[15:1]};
        rdy_pat <= nxt;
        rdy_age <= rdy_age + 6'd1;
        i_m_axis_tready <= nxt[0];
    end

    // Result monitor: compare each word with the oldest expectation
    always @(posedge i_clk) begin : result_mon
        logic [111:0] want;
        longint unsigned m, ev, av;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (result_due.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, o_m_axis_tdata);
                n_errors++;
            end else begin
                want = result_due.pop_front();
                for (int i = 0; i < NF; i++) begin
                    m = (64'd1 << F_W[i]) - 1;
                    ev = 64'(want >> F_LSB[i]) & m;
                    av = 64'(o_m_axis_tdata >> F_LSB[i]) & m;
                    if (ev !== av) begin
                        $display("%0t: result %0d %s mismatch, expected %0d actual %0d",
                                 $realtime, n_results, f_name[i], ev, av);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin : stim
        int n_rand;
        int ops;
        int w;
        int seq_no;
        logic [31:0] flen;

        // Directed: requests on a closed stream and unknown kinds
        add_req(REQ_CONSUME, $urandom, $urandom, 16'hFFFF, 10'd512, 1'b1, 1'b0);
        add_req(REQ_SEEK, 32'd0, 32'd0, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_PUMP, 32'd0, 32'd0, 16'd0, 10'd512, 1'b0, 1'b0);
        add_req(REQ_UNUSED_5, $urandom, $urandom, 16'($urandom), 10'd0, 1'b0, 1'b0);
        // Empty stream: pump books an empty fill and ends
        add_req(REQ_OPEN, 32'd0, 32'd0, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_PUMP, 32'd0, 32'd0, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_CONSUME, 32'd0, 32'd0, 16'd100, 10'd0, 1'b0, 1'b0);
        // Short stream, short and oversized deliveries
        add_req(REQ_OPEN, 32'd700, 32'hFFFF_FFFF, 16'd0, 10'd0, 1'b0, 1'b1);
        add_req(REQ_PUMP, 32'd0, 32'd0, 16'd0, 10'd512, 1'b0, 1'b0);
        add_req(REQ_PUMP, 32'd0, 32'd0, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_PUMP, 32'd0, 32'd0, 16'd0, 10'd512, 1'b0, 1'b0);
        add_req(REQ_CONSUME, 32'd0, 32'd0, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_CONSUME, 32'd0, 32'd0, 16'hFFFF, 10'd0, 1'b0, 1'b0);
        add_req(REQ_CONSUME, 32'd0, 32'd0, 16'd1, 10'd0, 1'b0, 1'b0);
        add_req(REQ_PUMP, 32'd0, 32'd0, 16'd0, 10'd512, 1'b0, 1'b0);
        // Failures: seek error, then consume and pump in error
        add_req(REQ_SEEK, 32'd0, 32'd5, 16'd0, 10'd0, 1'b1, 1'b0);
        add_req(REQ_CONSUME, 32'd0, 32'd0, 16'd10, 10'd0, 1'b0, 1'b0);
        add_req(REQ_PUMP, 32'd0, 32'd0, 16'd0, 10'd512, 1'b0, 1'b0);
        // Maximum length, then read failure
        add_req(REQ_OPEN, 32'hFFFF_FFFF, 32'd0, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_PUMP, 32'd0, 32'd0, 16'd0, 10'd512, 1'b1, 1'b0);
        // Seeks past the end and inside, close, unknown kind
        add_req(REQ_OPEN, 32'd1000, 32'd0, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_SEEK, 32'd0, 32'hFFFF_FFFF, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_SEEK, 32'd0, 32'd10, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_CLOSE, 32'd0, 32'd0, 16'd0, 10'd0, 1'b0, 1'b0);
        add_req(REQ_UNUSED_7, 32'd0, 32'd0, 16'd0, 10'd0, 1'b0, 1'b0);

        // Random streams: open, then mostly pumps and consumes
        n_rand = 0;
        seq_no = 0;
        while (n_rand < RAND_ITEMS) begin
            flen = pick_length();
            add_req(REQ_OPEN, flen, $urandom, 16'($urandom), 10'($urandom_range(0, 512)),
                    1'($urandom), (seq_no % 12) == 11);
            n_rand++;
            seq_no++;
            ops = $urandom_range(10, 80);
            for (int k = 0; k < ops && n_rand < RAND_ITEMS; k++) begin
                w = $urandom_range(0, 99);
                if (w < 52)
                    add_req(REQ_PUMP, $urandom, $urandom, 16'($urandom), pick_deliv(),
                            $urandom_range(0, 49) == 0, 1'b0);
                else if (w < 88)
                    add_req(REQ_CONSUME, $urandom, $urandom, pick_maxb(),
                            10'($urandom_range(0, 512)), 1'($urandom), 1'b0);
                else if (w < 94)
                    add_req(REQ_SEEK, $urandom,
                            ($urandom_range(0, 3) == 0) ? $urandom
                                                        : $urandom_range(0, flen),
                            16'($urandom), 10'($urandom_range(0, 512)),
                            $urandom_range(0, 9) == 0, 1'b0);
                else if (w < 97)
                    add_req(REQ_CLOSE, $urandom, $urandom, 16'($urandom),
                            10'($urandom_range(0, 512)), 1'($urandom), 1'b0);
                else
                    add_req(REQ_OPEN, pick_length(), $urandom, 16'($urandom),
                            10'($urandom_range(0, 512)), 1'($urandom), 1'b0);
                n_rand++;
            end
        end

        // Reset, then let the driver run dry
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending.size() > 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (result_due.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d results: %0d storage reads, %0d grants,",
                 n_accepted, n_results, n_reads, n_grants);
        $display("  %0d buffer swaps, %0d end-of-stream results, %0d mismatches",
                 n_swaps, n_end_hits, n_errors);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("Timeout: %0d results still outstanding", result_due.size());
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/dbp_pkg.sv
hw/rtl/dbp_front.sv
hw/rtl/dbp_queue.sv
hw/rtl/dbp_back.sv
hw/rtl/double_buffer_prefetch_ctrl.sv
sim/tb_double_buffer_prefetch_ctrl.sv
